// File: rtl/core/signed_binary_to_base12_text_macros.svh
// Assertion macros shared by the checker of the base-12 text block.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef SIGNED_BINARY_TO_BASE12_TEXT_MACROS_SVH
`define SIGNED_BINARY_TO_BASE12_TEXT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SB12_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SB12_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/sb12_pkg.sv
// Package for the signed binary to base-12 text block: character codes,
// digit constants, the status struct and helper functions. No dependencies.
`timescale 1ns / 1ps

package sb12_pkg;

   localparam int IN_WIDTH      = 64;
   localparam int CHAR_WIDTH    = 7;
   localparam int DIGIT_WIDTH   = 4;
   localparam int BITS_PER_STEP = 4;

   // ASCII codes of the characters the block can produce.
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 7'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TEN    = 7'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ELEVEN = 7'h45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 7'h2D;

   // Digit values used by the conversion and by the character mapping.
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN    = 4'd10;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ELEVEN = 4'd11;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_HALF   = 4'd6;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJUST = 4'd2;

   // Status of a finished conversion, passed from converter to emitter.
   typedef struct packed {
      logic valid;
      logic neg;
   } conv_status_type;

   // Number of base-12 digits needed for the largest magnitude, 2^(width-1).
   function automatic int digits_for_width(input int width);
      logic [127:0] top;
      logic [127:0] power;
      int           count;
      top   = 128'd1 << (width - 1);
      power = 128'd12;
      count = 1;
      for (int i = 0; i < 40; i++) begin
         if (power <= top) begin
            count = count + 1;
            power = power * 128'd12;
         end
      end
      return count;
   endfunction

   // ASCII character for one base-12 digit.
   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d == DIGIT_TEN) begin
         c = CHAR_TEN;
      end else if (d == DIGIT_ELEVEN) begin
         c = CHAR_ELEVEN;
      end else begin
         c = CHAR_ZERO + CHAR_WIDTH'(d);
      end
      return c;
   endfunction

endpackage

// File: rtl/core/sb12_front.sv
// Front end: accepts values, splits them into sign and magnitude and holds
// them in a two-entry queue for the converter. Depends on sb12_pkg.
`timescale 1ns / 1ps

module sb12_front #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [sb12_pkg::IN_WIDTH-1:0] req_value,
   output logic                         req_stall,
   output logic                         q_valid,
   output logic                         q_neg,
   output logic [VALUE_WIDTH-1:0]       q_mag,
   input  logic                         q_pop
);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   logic [VALUE_WIDTH-1:0] value_low;
   logic                   value_neg;
   logic [VALUE_WIDTH-1:0] value_mag;
   logic                   push;

   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   logic                   neg_mem [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0] mag_mem [QUEUE_DEPTH];

   // Sign and magnitude; the most negative value negates to itself, which
   // read as unsigned is exactly its magnitude.
   assign value_low = req_value[VALUE_WIDTH-1:0];
   assign value_neg = value_low[VALUE_WIDTH-1];
   assign value_mag = value_neg ? ((~value_low) + VALUE_WIDTH'(1)) : value_low;

   assign req_stall = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   assign q_valid = (count_ff != '0);
   assign q_neg   = neg_mem[rd_ptr_ff];
   assign q_mag   = mag_mem[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(1);
      end
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + CNT_WIDTH'(1);
         2'b01:   count_in = count_ff - CNT_WIDTH'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         neg_mem[wr_ptr_ff] <= value_neg;
         mag_mem[wr_ptr_ff] <= value_mag;
      end
   end

endmodule

// File: rtl/core/sb12_convert.sv
// Back end converter: turns a magnitude into packed base-12 digits with a
// shift-and-adjust loop, four input bits per cycle. Depends on sb12_pkg.
`timescale 1ns / 1ps

module sb12_convert #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  logic                              q_neg,
   input  logic [VALUE_WIDTH-1:0]            q_mag,
   output logic                              q_pop,
   output sb12_pkg::conv_status_type         status,
   output logic [sb12_pkg::digits_for_width(VALUE_WIDTH)*sb12_pkg::DIGIT_WIDTH-1:0] digits,
   input  logic                              take
);

   localparam int ND     = sb12_pkg::digits_for_width(VALUE_WIDTH);
   localparam int DGW    = sb12_pkg::DIGIT_WIDTH;
   localparam int BPS    = sb12_pkg::BITS_PER_STEP;
   localparam int DW     = ND * DGW;
   localparam int STEPS  = (VALUE_WIDTH + BPS - 1) / BPS;
   localparam int PAD_W  = STEPS * BPS;
   localparam int SW     = $clog2(STEPS);

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_BUSY,
      CONV_DONE
   } conv_state_type;

   conv_state_type   state_ff, state_in;
   logic             neg_ff, neg_in;
   logic [PAD_W-1:0] bits_ff, bits_in;
   logic [DW-1:0]    bcd_ff, bcd_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [DW-1:0]    work;
   logic             load;

   // Four dependent shift-and-adjust steps: any digit of six or more gets
   // two added so that doubling carries into the next digit.
   always_comb begin
      work = bcd_ff;
      for (int b = 0; b < BPS; b++) begin
         for (int j = 0; j < ND; j++) begin
            if (work[j*DGW +: DGW] >= sb12_pkg::DIGIT_HALF) begin
               work[j*DGW +: DGW] = work[j*DGW +: DGW] + sb12_pkg::DIGIT_ADJUST;
            end
         end
         work = {work[DW-2:0], bits_ff[PAD_W-1-b]};
      end
   end

   // A new item is taken when idle, or when the finished one is handed over.
   assign load  = q_valid && ((state_ff == CONV_IDLE) || ((state_ff == CONV_DONE) && take));
   assign q_pop = load;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      bits_in  = bits_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      if (load) begin
         state_in = CONV_BUSY;
         neg_in   = q_neg;
         bits_in  = PAD_W'(q_mag);
         bcd_in   = '0;
         step_in  = '0;
      end else begin
         unique case (state_ff)
            CONV_IDLE: begin
               state_in = CONV_IDLE;
            end
            CONV_BUSY: begin
               bcd_in  = work;
               bits_in = bits_ff << BPS;
               step_in = step_ff + SW'(1);
               if (step_ff == SW'(STEPS - 1)) begin
                  state_in = CONV_DONE;
               end
            end
            CONV_DONE: begin
               if (take) begin
                  state_in = CONV_IDLE;
               end
            end
            default: begin
               state_in = CONV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff  <= neg_in;
      bits_ff <= bits_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
   end

   assign status.valid = (state_ff == CONV_DONE);
   assign status.neg   = neg_ff;
   assign digits       = bcd_ff;

endmodule

// File: rtl/core/sb12_emit.sv
// Back end emitter: takes finished digits and sends the sign and the
// significant digits as ASCII, one transfer per unstalled cycle. Needs sb12_pkg.
`timescale 1ns / 1ps

module sb12_emit #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sb12_pkg::conv_status_type         status,
   input  logic [sb12_pkg::digits_for_width(VALUE_WIDTH)*sb12_pkg::DIGIT_WIDTH-1:0] digits,
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sb12_pkg::CHAR_WIDTH-1:0]   rsp_char_code,
   output logic                              rsp_last
);

   localparam int ND  = sb12_pkg::digits_for_width(VALUE_WIDTH);
   localparam int DGW = sb12_pkg::DIGIT_WIDTH;
   localparam int DW  = ND * DGW;
   localparam int CW  = $clog2(ND + 1);
   localparam int IW  = $clog2(ND);

   logic                          busy_ff, busy_in;
   logic                          sign_ff, sign_in;
   logic [CW-1:0]                 left_ff, left_in;
   logic [DW-1:0]                 dig_ff, dig_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sb12_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                          last_ff, last_in;

   logic [CW-1:0]                 sig_count;
   logic [IW-1:0]                 idx;
   logic                          can_out;
   logic                          final_digit;

   // Count of significant digits; zero still shows one digit.
   always_comb begin
      sig_count = CW'(1);
      for (int j = 0; j < ND; j++) begin
         if (digits[j*DGW +: DGW] != '0) begin
            sig_count = CW'(j + 1);
         end
      end
   end

   assign take        = !busy_ff && status.valid;
   assign can_out     = !rsp_valid_ff || !rsp_stall;
   assign idx         = IW'(left_ff - CW'(1));
   assign final_digit = (left_ff == CW'(1));

   // Character sequencing into the output register.
   always_comb begin
      busy_in      = busy_ff;
      sign_in      = sign_ff;
      left_in      = left_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         sign_in = status.neg;
         left_in = sig_count;
         dig_in  = digits;
      end else if (busy_ff && can_out) begin
         rsp_valid_in = 1'b1;
         if (sign_ff) begin
            char_in = sb12_pkg::CHAR_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else begin
            char_in = sb12_pkg::digit_char(dig_ff[idx*DGW +: DGW]);
            last_in = final_digit;
            left_in = left_ff - CW'(1);
            if (final_digit) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff <= left_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

// File: rtl/core/signed_binary_to_base12_text.sv
// Top level of the signed binary to base-12 text block: front end, converter
// and emitter. Depends on sb12_pkg, sb12_front, sb12_convert and sb12_emit.
//
// Usage: req_value carries a two's complement number whose low VALUE_WIDTH
// bits are used; a transfer happens when req_valid is high and req_stall low.
// Each number comes out on the rsp_ channel as ASCII characters, most
// significant first: an optional '-', then digits '0'-'9', 'X' and 'E'.
// rsp_last marks the final character of a number; zero is a single '0'.
// A transferred number passes through the queue, the converter and the
// emitter's output register before its first character is shown; the
// converter takes four bits of magnitude per cycle. The emitter sends one
// character a cycle while rsp_stall is low, and the converter works on the
// next number meanwhile.
// A two-entry queue in the front end takes numbers while the back is busy.
// Reset is synchronous: all queued numbers and pending text are dropped.
// While rsp_stall is high the shown character holds and the block fills up,
// then raises req_stall.
`timescale 1ns / 1ps

module signed_binary_to_base12_text #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [sb12_pkg::IN_WIDTH-1:0]   req_value,
   output logic                            req_stall,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sb12_pkg::CHAR_WIDTH-1:0] rsp_char_code,
   output logic                            rsp_last
);

   localparam int ND = sb12_pkg::digits_for_width(VALUE_WIDTH);
   localparam int DW = ND * sb12_pkg::DIGIT_WIDTH;

   logic                      q_valid;
   logic                      q_neg;
   logic [VALUE_WIDTH-1:0]    q_mag;
   logic                      q_pop;
   sb12_pkg::conv_status_type conv_status;
   logic [DW-1:0]             conv_digits;
   logic                      conv_take;

   // Intake and sign/magnitude split.
   sb12_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_value (req_value),
      .req_stall (req_stall),
      .q_valid   (q_valid),
      .q_neg     (q_neg),
      .q_mag     (q_mag),
      .q_pop     (q_pop)
   );

   // Binary to base-12 digits.
   sb12_convert #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_convert (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_neg   (q_neg),
      .q_mag   (q_mag),
      .q_pop   (q_pop),
      .status  (conv_status),
      .digits  (conv_digits),
      .take    (conv_take)
   );

   // Digits to characters.
   sb12_emit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .status        (conv_status),
      .digits        (conv_digits),
      .take          (conv_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

// File: rtl/core/sb12_checker.sv
// Port checker for the base-12 text block, bound to the top level.
// Depends on sb12_pkg and signed_binary_to_base12_text_macros.svh.
`timescale 1ns / 1ps
`include "signed_binary_to_base12_text_macros.svh"

module sb12_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sb12_pkg::CHAR_WIDTH-1:0] rsp_char_code,
   input logic                            rsp_last
);

   logic req_transfer;
   logic char_is_digit;
   logic char_is_legal;

   assign req_transfer  = req_valid && !req_stall;
   assign char_is_digit = (rsp_char_code >= sb12_pkg::CHAR_ZERO) &&
                          (rsp_char_code <= sb12_pkg::CHAR_NINE);
   assign char_is_legal = char_is_digit || (rsp_char_code == sb12_pkg::CHAR_TEN) ||
                          (rsp_char_code == sb12_pkg::CHAR_ELEVEN) ||
                          (rsp_char_code == sb12_pkg::CHAR_MINUS);

   // A stalled character and its flag hold until taken.
   `SB12_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_char_code) && $stable(rsp_last), "stalled result changed")

   // A sign is always followed by digits of the same number.
   `SB12_ASSERT_IMPLIES(a_minus_not_last, rsp_valid && (rsp_char_code == sb12_pkg::CHAR_MINUS), !rsp_last, "minus sign flagged as last")

   // Only digit characters and the sign ever appear.
   `SB12_ASSERT_IMPLIES(a_char_legal, rsp_valid, char_is_legal, "illegal character code")

   // Reset leaves nothing pending on the output and room on the input.
   `SB12_ASSERT_IMPLIES(a_reset_clears, $past(reset), !rsp_valid && !req_stall && !$past(req_transfer), "state left after reset")

endmodule

bind signed_binary_to_base12_text sb12_checker u_sb12_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last)
);
